// File: rtl/cte_pkg.sv
// Shared constants and types for the charger telemetry smoothing block.
package cte_pkg;

    // Default fraction bits kept in each current filter.
    localparam int CTE_FRACTION_BITS = 8;

    // Smoothing weight register, in 1/256 units.
    localparam logic [8:0] WEIGHT_MIN   = 9'd26;
    localparam logic [8:0] WEIGHT_MAX   = 9'd256;
    localparam logic [8:0] WEIGHT_RESET = 9'd205;
    localparam logic [8:0] WEIGHT_FULL  = 9'd256;

    // Register indexes.
    localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

    // Source field codes that mean OTG is running.
    localparam logic [3:0] SRC_OTG_A = 4'h7;
    localparam logic [3:0] SRC_OTG_B = 4'hC;

    // Stream widths.
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 136;

    // Step strobes from the sequencer to each lane.
    typedef struct packed {
        logic mul_en;   // register the two weighted products
        logic acc_en;   // sum, scale and store the filter
        logic first;    // load the sample instead of blending
    } cte_lane_ctl_t;

endpackage

// File: rtl/cte_lane.sv
// One current lane: EMA filter, rounding to mA and power product.
module cte_lane
    import cte_pkg::*;
#(
    parameter int FRACTION_BITS = CTE_FRACTION_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cte_lane_ctl_t       ctl,
    input  logic [8:0]          weight,
    input  logic signed [15:0]  cur_sample,
    input  logic signed [15:0]  volt_sample,
    output logic signed [15:0]  cur_avg,
    output logic signed [31:0]  power_uw
);

    localparam int FW = 16 + FRACTION_BITS;   // filter word
    localparam int PW = 26 + FRACTION_BITS;   // weighted product
    localparam int AW = 27 + FRACTION_BITS;   // product sum
    localparam int RW = FW + 1;               // rounding sum
    localparam logic signed [AW-1:0] ACC_HALF = AW'(128);
    localparam logic signed [RW-1:0] RND_HALF = RW'(1) <<< (FRACTION_BITS - 1);

    logic signed [PW-1:0] p_new_reg, p_new_next;
    logic signed [PW-1:0] p_old_reg, p_old_next;
    logic signed [FW-1:0] filter_reg, filter_next;
    logic signed [FW-1:0] x_shifted;
    logic signed [9:0]    w_s;
    logic signed [9:0]    w_inv;
    logic signed [AW-1:0] acc_sum;
    logic signed [AW-1:0] acc_scaled;
    logic signed [RW-1:0] rnd_sum;
    logic signed [RW-1:0] rnd_scaled;

    assign x_shifted = {cur_sample, {FRACTION_BITS{1'b0}}};
    assign w_s       = $signed({1'b0, weight});
    assign w_inv     = $signed({1'b0, WEIGHT_FULL} - {1'b0, weight});

    assign p_new_next = PW'(w_s) * PW'(x_shifted);
    assign p_old_next = PW'(w_inv) * PW'(filter_reg);

    // floor((w*x + (256-w)*f + 128) / 256); stays between old and new value
    assign acc_sum    = AW'(p_new_reg) + AW'(p_old_reg) + ACC_HALF;
    assign acc_scaled = acc_sum >>> 8;

    always_comb begin
        filter_next = filter_reg;
        if (ctl.acc_en) begin
            if (ctl.first) begin
                filter_next = x_shifted;
            end else begin
                filter_next = FW'(acc_scaled);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else begin
            filter_reg <= filter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            p_new_reg <= p_new_next;
            p_old_reg <= p_old_next;
        end
    end

    // round half up to whole mA, then power in uW
    assign rnd_sum    = RW'(filter_reg) + RND_HALF;
    assign rnd_scaled = rnd_sum >>> FRACTION_BITS;
    assign cur_avg    = 16'(rnd_scaled);
    assign power_uw   = 32'(volt_sample) * 32'(cur_avg);

endmodule

// File: rtl/cte_merge.sv
// Output stage: joins lane results, decodes status and holds the result item.
module cte_merge
    import cte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic signed [15:0]   bus_avg,
    input  logic signed [15:0]   bat_avg,
    input  logic signed [31:0]   bus_pow,
    input  logic signed [31:0]   bat_pow,
    input  logic signed [15:0]   bus_volt,
    input  logic signed [15:0]   bat_volt,
    input  logic [7:0]           status,
    output logic                 out_free,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_DATA_W-1:0]  m_tdata
);

    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg;
    logic [3:0]          src;
    logic                otg;

    assign src      = status[4:1];
    assign otg      = (src == SRC_OTG_A) || (src == SRC_OTG_B);
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {4'b0000, otg, status[7:5], bus_pow, bat_pow,
                         bat_volt, bus_volt, bat_avg, bus_avg};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: rtl/charger_telemetry_ema_unit.sv
// Top level of the charger telemetry smoothing block.
// Usage:
//   s_ channel takes one charger ADC snapshot per item; m_ channel returns one
//   result item per snapshot, in order. The smoothing weight is written over
//   the APB-style port at address 0 (clamped to 26..256 on write, reads back
//   the stored value); write it only while the block is idle.
//   The bus and battery currents run in two identical lanes, each with its
//   own EMA filter and power multiplier; the output stage merges them with
//   the passed-through voltages and the decoded status byte.
// Sequence:
//   An item passes the accept step, the product step and the filter update,
//   then the power multiply lands in the output register. s_tready is high
//   only in the accept step, so no new item is taken before the last one
//   has left the final step; m_tvalid is set by that step's output load.
// Reset:
//   aresetn low (synchronous) clears both filters, the weight to 205, the
//   output valid and rearms the first-sample load for the next item.
// Stall:
//   The output register holds its item while m_tready is low. The next item
//   is still accepted and waits in the final step until the output frees up.
module charger_telemetry_ema_unit
    import cte_pkg::*;
#(
    parameter int FRACTION_BITS = CTE_FRACTION_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: bus_current_raw[15:0], battery_current_raw[31:16],
    //          bus_voltage_raw[47:32], battery_voltage_raw[63:48],
    //          charger_status_byte[71:64]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    // m_tdata: bus_current_avg[15:0], battery_current_avg[31:16],
    //          bus_voltage_out[47:32], battery_voltage_out[63:48],
    //          battery_power_uw[95:64], bus_power_uw[127:96],
    //          charge_phase[130:128], otg_active[131], zero[135:132]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_PWR  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic [8:0] weight_reg, weight_next;

    // held snapshot
    logic signed [15:0] bus_i_reg, bat_i_reg, bus_v_reg, bat_v_reg;
    logic [7:0]         stat_reg;

    logic               s_accept;
    logic               cfg_write;
    logic [8:0]         wdata;
    logic               out_free;
    logic               out_load;
    cte_lane_ctl_t      lane_ctl;

    logic signed [15:0] bus_avg, bat_avg;
    logic signed [31:0] bus_pow, bat_pow;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wdata     = pwdata[8:0];

    always_comb begin
        weight_next = weight_reg;
        if (cfg_write && (paddr[2] == REG_SMOOTHING_WEIGHT)) begin
            if (wdata < WEIGHT_MIN) begin
                weight_next = WEIGHT_MIN;
            end else if (wdata > WEIGHT_MAX) begin
                weight_next = WEIGHT_MAX;
            end else begin
                weight_next = wdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_SMOOTHING_WEIGHT) ? {23'd0, weight_reg} : 32'd0;

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_PWR) && out_free;

    always_comb begin
        state_next      = state_reg;
        first_next      = first_reg;
        lane_ctl.mul_en = 1'b0;
        lane_ctl.acc_en = 1'b0;
        lane_ctl.first  = first_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                lane_ctl.mul_en = 1'b1;
                state_next      = ST_ACC;
            end
            ST_ACC: begin
                lane_ctl.acc_en = 1'b1;
                first_next      = 1'b0;
                state_next      = ST_PWR;
            end
            ST_PWR: begin
                // wait here while the previous result is still unclaimed
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            first_reg  <= 1'b1;
            weight_reg <= WEIGHT_RESET;
        end else begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bus_i_reg <= s_tdata[15:0];
            bat_i_reg <= s_tdata[31:16];
            bus_v_reg <= s_tdata[47:32];
            bat_v_reg <= s_tdata[63:48];
            stat_reg  <= s_tdata[71:64];
        end
    end

    // ---------------- lanes ----------------
    cte_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_bus (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (lane_ctl),
        .weight      (weight_reg),
        .cur_sample  (bus_i_reg),
        .volt_sample (bus_v_reg),
        .cur_avg     (bus_avg),
        .power_uw    (bus_pow)
    );

    cte_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_bat (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (lane_ctl),
        .weight      (weight_reg),
        .cur_sample  (bat_i_reg),
        .volt_sample (bat_v_reg),
        .cur_avg     (bat_avg),
        .power_uw    (bat_pow)
    );

    // ---------------- merge and output ----------------
    cte_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .bus_avg  (bus_avg),
        .bat_avg  (bat_avg),
        .bus_pow  (bus_pow),
        .bat_pow  (bat_pow),
        .bus_volt (bus_v_reg),
        .bat_volt (bat_v_reg),
        .status   (stat_reg),
        .out_free (out_free),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // ---------------- assertions ----------------
    // an accepted item always starts the product step next
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_MUL))
        else $error("accepted item did not enter the product step");

    // filter update clears the first-sample flag
    a_first_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |=> !first_reg)
        else $error("first-sample flag still set after filter update");

    // a finished item always shows up on the output
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("finished item not presented on the output");

    // a weight stored by a write is always inside the clamp range
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> (weight_reg >= WEIGHT_MIN) && (weight_reg <= WEIGHT_MAX))
        else $error("smoothing weight outside its range");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the charger telemetry smoothing block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cte_pkg::*;

    // Fraction bits the block is built with (default parameter).
    localparam int FB = CTE_FRACTION_BITS;

    // Register map: one register at byte address 4*index.
    localparam logic [2:0] ADDR_WEIGHT   = {REG_SMOOTHING_WEIGHT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'h4;

    // Cycles to let the pipeline settle before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 90;
    localparam int PHASE_COUNT   = 9;

    // One ADC snapshot as it travels on s_tdata, last field in the low bits.
    typedef struct packed {
        logic        [7:0]  status;
        logic signed [15:0] battery_voltage;
        logic signed [15:0] bus_voltage;
        logic signed [15:0] battery_current;
        logic signed [15:0] bus_current;
    } snapshot_t;

    // One result item as it travels on m_tdata.
    typedef struct packed {
        logic        [3:0]  pad;
        logic               otg_active;
        logic        [2:0]  charge_phase;
        logic signed [31:0] bus_power_uw;
        logic signed [31:0] battery_power_uw;
        logic signed [15:0] battery_voltage;
        logic signed [15:0] bus_voltage;
        logic signed [15:0] battery_current_avg;
        logic signed [15:0] bus_current_avg;
    } telemetry_t;

    // Tracks the block's filters and weight and holds the telemetry still owed.
    class telemetry_book;
        telemetry_t  owed[$];
        longint      bus_filter;
        longint      battery_filter;
        bit          load_next;
        int unsigned weight;
        int          errors;
        int          results_seen;

        function new();
            bus_filter     = 0;
            battery_filter = 0;
            load_next      = 1'b1;
            weight         = 32'(WEIGHT_RESET);
            errors         = 0;
            results_seen   = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Register write as the block sees it: low 9 bits, clamped on entry.
        function void write_register(logic [2:0] addr, logic [31:0] data);
            int unsigned v;
            if (addr[2] != REG_SMOOTHING_WEIGHT) begin
                return;
            end
            v = 32'(data[8:0]);
            if (v < WEIGHT_MIN) v = 32'(WEIGHT_MIN);
            if (v > WEIGHT_MAX) v = 32'(WEIGHT_MAX);
            weight = v;
        endfunction

        // Blend, round half up, floor to the filter's fraction grid.
        function longint blend(longint filt, logic signed [15:0] sample);
            longint acc;
            acc = longint'(weight) * (longint'(sample) <<< FB)
                + longint'(WEIGHT_FULL - weight) * filt + longint'(WEIGHT_FULL / 2);
            return acc >>> 8;
        endfunction

        function void note_input(snapshot_t s);
            telemetry_t r;
            longint     avg_bus;
            longint     avg_bat;
            if (load_next) begin
                bus_filter     = longint'(s.bus_current) <<< FB;
                battery_filter = longint'(s.battery_current) <<< FB;
                load_next      = 1'b0;
            end else begin
                bus_filter     = blend(bus_filter, s.bus_current);
                battery_filter = blend(battery_filter, s.battery_current);
            end
            avg_bus = (bus_filter + (longint'(1) <<< (FB - 1))) >>> FB;
            avg_bat = (battery_filter + (longint'(1) <<< (FB - 1))) >>> FB;
            r.bus_current_avg     = avg_bus[15:0];
            r.battery_current_avg = avg_bat[15:0];
            r.bus_voltage         = s.bus_voltage;
            r.battery_voltage     = s.battery_voltage;
            r.battery_power_uw    = 32'(longint'(s.battery_voltage) * avg_bat);
            r.bus_power_uw        = 32'(longint'(s.bus_voltage) * avg_bus);
            r.charge_phase        = s.status[7:5];
            r.otg_active          = (s.status[4:1] == SRC_OTG_A) ||
                                    (s.status[4:1] == SRC_OTG_B);
            r.pad                 = '0;
            owed.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, longint got, longint want);
            if (got != want) begin
                report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                          results_seen, name, got, want));
            end
        endtask

        task check_result(telemetry_t got);
            telemetry_t want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none owed", results_seen));
                results_seen++;
                return;
            end
            want = owed.pop_front();
            compare_field("bus_current_avg", got.bus_current_avg, want.bus_current_avg);
            compare_field("battery_current_avg", got.battery_current_avg,
                          want.battery_current_avg);
            compare_field("bus_voltage_out", got.bus_voltage, want.bus_voltage);
            compare_field("battery_voltage_out", got.battery_voltage, want.battery_voltage);
            compare_field("battery_power_uw", got.battery_power_uw, want.battery_power_uw);
            compare_field("bus_power_uw", got.bus_power_uw, want.bus_power_uw);
            compare_field("charge_phase", got.charge_phase, want.charge_phase);
            compare_field("otg_active", got.otg_active, want.otg_active);
            compare_field("padding", got.pad, want.pad);
            results_seen++;
        endtask
    endclass

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Stream and register port signals; the ones the bench drives are known from time zero.
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Back-pressure percentages, changed between phases.
    int send_idle_pct = 15;
    int recv_idle_pct = 71;

    // Slowly wandering current levels for the well-behaved part of the traffic.
    int bus_level = 1500;
    int bat_level = -800;

    telemetry_book book = new();

    charger_telemetry_ema_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, driven on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: pre-edge values are what the handshake moved.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            book.check_result(telemetry_t'(m_tdata));
        end
    end

    // Offer one snapshot, with random idle cycles ahead of it; returns at the
    // accepting edge with tvalid still high so back-to-back items stay clean.
    task send_snapshot(snapshot_t snap);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= snap;
        do @(posedge aclk); while (!s_tready);
        book.note_input(snap);
    endtask

    // Stop sending and wait until every owed result has come back.
    task drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        book.write_register(addr, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read back the weight and compare with the clamped value we expect.
    task apb_read_weight();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WEIGHT;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(book.weight)) begin
            book.report_mismatch($sformatf("weight read %0d expected %0d",
                                           prdata, book.weight));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random snapshot: mostly noisy steady levels with occasional level
    // jumps, some full-range noise, some rail values.
    function snapshot_t make_snapshot();
        snapshot_t s;
        int        roll;
        int        pick;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 6) bus_level = $urandom_range(65535) - 32768;
        if ($urandom_range(99) < 6) bat_level = $urandom_range(65535) - 32768;
        if (roll < 20) begin
            s = snapshot_t'(72'({$urandom(), $urandom(), $urandom()}));
        end else if (roll < 32) begin
            pick = $urandom_range(3);
            s.bus_current     = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7FFF :
                                (pick == 2) ? 16'sh0000 : 16'shFFFF;
            pick = $urandom_range(3);
            s.battery_current = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7FFF :
                                (pick == 2) ? 16'sh0000 : 16'shFFFF;
            s.bus_voltage     = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            s.battery_voltage = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            s.status          = 8'($urandom_range(255));
        end else begin
            s.bus_current     = 16'(bus_level + int'($urandom_range(80)) - 40);
            s.battery_current = 16'(bat_level + int'($urandom_range(80)) - 40);
            s.bus_voltage     = 16'(int'($urandom_range(20000)) + 4000);
            s.battery_voltage = 16'(int'($urandom_range(13000)) + 3000);
            s.status          = 8'($urandom_range(255));
        end
        // Push a fair share through the OTG source codes.
        if ($urandom_range(99) < 25) begin
            s.status[4:1] = $urandom_range(1) ? SRC_OTG_A : SRC_OTG_B;
        end
        return s;
    endfunction

    // Directed opening, run at the reset weight: the first snapshot (which
    // loads the filters outright) at the rails, then every source code and
    // every charge phase with rail currents and voltages.
    task run_directed();
        snapshot_t s;
        s.bus_current     = 16'sh8000;
        s.battery_current = 16'sh7FFF;
        s.bus_voltage     = 16'sh7FFF;
        s.battery_voltage = 16'sh8000;
        s.status          = {3'd0, SRC_OTG_A, 1'b0};
        send_snapshot(s);
        s.bus_current     = 16'sh7FFF;
        s.battery_current = 16'sh8000;
        s.bus_voltage     = 16'sh8000;
        s.battery_voltage = 16'sh8000;
        s.status          = {3'd7, SRC_OTG_B, 1'b1};
        send_snapshot(s);
        s = '0;
        send_snapshot(s);
        for (int k = 0; k < 16; k++) begin
            s.bus_current     = k[0] ? 16'sh8000 : 16'sh7FFF;
            s.battery_current = k[1] ? 16'sh7FFF : 16'sh8000;
            s.bus_voltage     = k[2] ? 16'sh7FFF : 16'sh8000;
            s.battery_voltage = k[3] ? 16'sh8000 : 16'sh7FFF;
            s.status          = {k[2:0], k[3:0], k[0]};
            send_snapshot(s);
        end
    endtask

    // Main sequence.
    initial begin
        logic [31:0] weight_value;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_read_weight();
        run_directed();
        drain_results();

        // Three idling modes in turn: light sender gaps with heavy receiver
        // stalls, the reverse, then full rate both ways.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 71;
            end else if (p < 6) begin
                send_idle_pct = 71;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Weight sweep: no smoothing, clamp low from zero, clamp high from
            // the 9-bit max, just below the floor, the floor itself, upper
            // pwdata bits ignored, just above full, then random.
            case (p)
                0:       weight_value = 32'd256;
                1:       weight_value = 32'd0;
                2:       weight_value = 32'h0000_01FF;
                3:       weight_value = 32'd25;
                4:       weight_value = 32'd26;
                5:       weight_value = 32'hABCD_0080;
                6:       weight_value = 32'd257;
                default: weight_value = {23'($urandom()), 9'($urandom())};
            endcase
            apb_write(ADDR_WEIGHT, weight_value);
            // A write past the last register must leave the weight alone.
            if (p % 3 == 1) apb_write(ADDR_UNMAPPED, $urandom());
            apb_read_weight();

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Once per phase the sender holds off until the block is empty.
                if (i == PHASE_ITEMS / 2) drain_results();
                send_snapshot(make_snapshot());
            end
            drain_results();
        end

        if (book.errors == 0 && book.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (a bit over 800 items).
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
